@@ hdl/lcfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCFS scheduler package
// Shared sizes, entry layouts and sequencer states of the completion order unit.
// ----------------------------------------------------------------------------
package lcfs_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    typedef struct packed {
        logic [7:0]  tag;
        logic [10:0] start;
        logic [9:0]  len;
    } task_t;

    typedef struct packed {
        logic [7:0] tag;
        logic [9:0] left;
    } slot_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_KEY,
        ST_SORT_GET,
        ST_SORT_CMP,
        ST_SORT_PLACE,
        ST_RUN_FIRST,
        ST_RUN_PREV,
        ST_RUN_CUR,
        ST_POP,
        ST_FINAL,
        ST_DRAIN
    } state_t;

endpackage
`default_nettype wire

@@ hdl/lcfs_preemptive_completion_order_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCFS preemptive completion order unit
// Loads a task set, sorts it by start minute and replays a preemptive
// last-come-first-served schedule, sending task tags in completion order.
// ----------------------------------------------------------------------------
// Usage:
// Tasks arrive on the input channel (in_valid/in_ready), one transfer per
// cycle while the block loads. The transfer with final_task set closes the
// set. Tasks beyond MAX_TASKS are ignored and raise dropped on every result.
// After the final transfer in_ready stays low while the block works. The
// stable insertion sort runs over the task memory, one compare per cycle.
// The replay then loads the first task as the running one and steps through
// the rest in order, visiting the pause stack when a completion leaves idle
// time; both memories have registered reads. Results leave
// through an output register (out_valid/out_ready), one per loaded task,
// run_end on the last. A stalled receiver holds the sequencer at its next
// completion; once the last result sits in the output register the block
// loads again.
// Reset empties the set, the pause stack and the overflow flag and leaves the
// output empty; the memory contents are not cleared.
// ----------------------------------------------------------------------------
module lcfs_preemptive_completion_order_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  task_tag,
    input  wire logic [10:0] start_minute,
    input  wire logic [9:0]  duration,
    input  wire logic        final_task,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       done_tag,
    output logic             run_end,
    output logic             dropped
);
    import lcfs_pkg::*;

    // Task memory and pause stack memory, each one write and one read port.
    task_t task_mem [MAX_TASKS];
    slot_t stk_mem  [MAX_TASKS];
    task_t task_rd_reg;
    slot_t stk_rd_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    task_t            key_reg, key_next;
    task_t            prev_reg, prev_next;
    logic [10:0]      rem_reg, rem_next;

    logic             out_valid_reg;
    logic [7:0]       done_tag_reg;
    logic             run_end_reg;
    logic             dropped_reg;

    logic             task_we, task_re, stk_we, stk_re;
    logic [IDX_W-1:0] task_waddr, task_raddr, stk_waddr, stk_raddr;
    task_t            task_wdata;
    slot_t            stk_wdata;
    logic             emit, emit_last;
    logic [7:0]       emit_tag;
    logic             can_emit;
    logic [CNT_W-1:0] last_idx;
    logic [10:0]      gap;
    logic [10:0]      len_ext;
    logic [11:0]      pop_rest;
    logic             at_last;

    assign can_emit = !out_valid_reg || out_ready;
    assign last_idx = count_reg - CNT_W'(1);
    assign gap      = task_rd_reg.start - prev_reg.start;
    assign len_ext  = {1'b0, prev_reg.len};
    assign pop_rest = {1'b0, rem_reg} - {2'b00, stk_rd_reg.left};
    assign at_last  = ({1'b0, i_reg} == last_idx);

    always_ff @(posedge clk)
    begin
        if (task_we)
        begin
            task_mem[task_waddr] <= task_wdata;
        end
        if (task_re)
        begin
            task_rd_reg <= task_mem[task_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            depth_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            depth_reg <= depth_next;
            ovf_reg   <= ovf_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        key_reg  <= key_next;
        prev_reg <= prev_next;
        rem_reg  <= rem_next;
        if (emit)
        begin
            done_tag_reg <= emit_tag;
            run_end_reg  <= emit_last;
            dropped_reg  <= ovf_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        depth_next = depth_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        key_next   = key_reg;
        prev_next  = prev_reg;
        rem_next   = rem_reg;
        task_we    = 1'b0;
        task_waddr = j_reg;
        task_wdata = key_reg;
        task_re    = 1'b0;
        task_raddr = i_reg;
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[IDX_W-1:0];
        stk_wdata  = '0;
        stk_re     = 1'b0;
        stk_raddr  = IDX_W'(depth_reg - CNT_W'(1));
        emit       = 1'b0;
        emit_tag   = prev_reg.tag;
        emit_last  = 1'b0;
        in_ready   = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (count_reg < CNT_W'(MAX_TASKS))
                    begin
                        task_we    = 1'b1;
                        task_waddr = count_reg[IDX_W-1:0];
                        task_wdata = '{tag: task_tag, start: start_minute, len: duration};
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (final_task)
                    begin
                        i_next     = IDX_W'(1);
                        state_next = (count_next > CNT_W'(1)) ? ST_SORT_KEY : ST_RUN_FIRST;
                    end
                end
            end

            ST_SORT_KEY:
            begin
                task_re    = 1'b1;
                task_raddr = i_reg;
                state_next = ST_SORT_GET;
            end

            ST_SORT_GET:
            begin
                key_next   = task_rd_reg;
                j_next     = i_reg;
                task_re    = 1'b1;
                task_raddr = i_reg - IDX_W'(1);
                state_next = ST_SORT_CMP;
            end

            ST_SORT_CMP:
            begin
                task_we    = 1'b1;
                task_waddr = j_reg;
                if (task_rd_reg.start > key_reg.start)
                begin
                    // Shift the larger entry up one place and keep walking down.
                    task_wdata = task_rd_reg;
                    j_next     = j_reg - IDX_W'(1);
                    if (j_reg == IDX_W'(1))
                    begin
                        state_next = ST_SORT_PLACE;
                    end
                    else
                    begin
                        task_re    = 1'b1;
                        task_raddr = j_reg - IDX_W'(2);
                    end
                end
                else
                begin
                    task_wdata = key_reg;
                    i_next     = i_reg + IDX_W'(1);
                    state_next = at_last ? ST_RUN_FIRST : ST_SORT_KEY;
                end
            end

            ST_SORT_PLACE:
            begin
                task_we    = 1'b1;
                task_waddr = j_reg;
                task_wdata = key_reg;
                i_next     = i_reg + IDX_W'(1);
                state_next = at_last ? ST_RUN_FIRST : ST_SORT_KEY;
            end

            ST_RUN_FIRST:
            begin
                task_re    = 1'b1;
                task_raddr = '0;
                depth_next = '0;
                state_next = ST_RUN_PREV;
            end

            ST_RUN_PREV:
            begin
                prev_next = task_rd_reg;
                if (count_reg == CNT_W'(1))
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    i_next     = IDX_W'(1);
                    task_re    = 1'b1;
                    task_raddr = IDX_W'(1);
                    state_next = ST_RUN_CUR;
                end
            end

            ST_RUN_CUR:
            begin
                if (gap > len_ext)
                begin
                    if (can_emit)
                    begin
                        emit      = 1'b1;
                        rem_next  = gap - len_ext;
                        prev_next = task_rd_reg;
                        if (depth_reg != '0)
                        begin
                            stk_re     = 1'b1;
                            state_next = ST_POP;
                        end
                        else if (at_last)
                        begin
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            task_re    = 1'b1;
                            task_raddr = i_reg + IDX_W'(1);
                        end
                    end
                end
                else if (gap == len_ext || can_emit || depth_reg >= CNT_W'(MAX_TASKS))
                begin
                    if (gap == len_ext)
                    begin
                        emit = 1'b1;
                    end
                    else if (depth_reg < CNT_W'(MAX_TASKS))
                    begin
                        // The new task preempts the running one.
                        stk_we     = 1'b1;
                        stk_wdata  = '{tag: prev_reg.tag, left: 10'(len_ext - gap)};
                        depth_next = depth_reg + CNT_W'(1);
                    end
                    if (gap != len_ext || can_emit)
                    begin
                        prev_next = task_rd_reg;
                        if (at_last)
                        begin
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            task_re    = 1'b1;
                            task_raddr = i_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        emit = 1'b0;
                    end
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = '{tag: prev_reg.tag, left: 10'(len_ext - gap)};
                    depth_next = depth_reg + CNT_W'(1);
                    prev_next  = task_rd_reg;
                    if (at_last)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        task_re    = 1'b1;
                        task_raddr = i_reg + IDX_W'(1);
                    end
                end
            end

            ST_POP:
            begin
                if (!pop_rest[11])
                begin
                    // The idle gap covers the paused task: it completes.
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        emit_tag   = stk_rd_reg.tag;
                        rem_next   = pop_rest[10:0];
                        depth_next = depth_reg - CNT_W'(1);
                        if (depth_reg > CNT_W'(1))
                        begin
                            stk_re    = 1'b1;
                            stk_raddr = IDX_W'(depth_reg - CNT_W'(2));
                        end
                        else if (at_last)
                        begin
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            task_re    = 1'b1;
                            task_raddr = i_reg + IDX_W'(1);
                            state_next = ST_RUN_CUR;
                        end
                    end
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = IDX_W'(depth_reg - CNT_W'(1));
                    stk_wdata  = '{tag: stk_rd_reg.tag, left: 10'(12'd0 - pop_rest)};
                    if (at_last)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        task_re    = 1'b1;
                        task_raddr = i_reg + IDX_W'(1);
                        state_next = ST_RUN_CUR;
                    end
                end
            end

            ST_FINAL:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_last = (depth_reg == '0);
                    if (depth_reg != '0)
                    begin
                        stk_re     = 1'b1;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_DRAIN:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_tag   = stk_rd_reg.tag;
                    emit_last  = (depth_reg == CNT_W'(1));
                    depth_next = depth_reg - CNT_W'(1);
                    if (depth_reg > CNT_W'(1))
                    begin
                        stk_re    = 1'b1;
                        stk_raddr = IDX_W'(depth_reg - CNT_W'(2));
                    end
                    else
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign done_tag  = done_tag_reg;
    assign run_end   = run_end_reg;
    assign dropped   = dropped_reg;

endmodule
`default_nettype wire

@@ hdl/lcfs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCFS scheduler port checker
// Watches the ports of the completion order unit over time.
// ----------------------------------------------------------------------------
module lcfs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       final_task,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] done_tag,
    input wire logic       run_end
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(done_tag) && $stable(run_end))
        else $error("result changed while stalled");

    a_busy_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && final_task |=> !in_ready)
        else $error("input taken right after the final task");

    a_keep_loading: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !final_task |=> in_ready)
        else $error("loading stopped before the final task");

endmodule

bind lcfs_preemptive_completion_order_unit lcfs_checker u_lcfs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .final_task (final_task),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .done_tag   (done_tag),
    .run_end    (run_end)
);
`default_nettype wire
